// ===== rtl/ffa_pkg.sv =====
// shared constants, types and codes of the slot allocator
package ffa_pkg;

    localparam int SLOTS       = 8;
    localparam int HANDLE_BITS = 32;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int COUNT_BITS  = $clog2(SLOTS + 1);

    typedef logic [SLOT_BITS-1:0]   slot_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [HANDLE_BITS-1:0] handle_t;

    typedef enum logic [1:0] {
        ACT_REINIT     = 2'd0,
        ACT_REGISTER   = 2'd1,
        ACT_UNREGISTER = 2'd2,
        ACT_LOOKUP     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NULL_DESC = 3'd1,
        ST_FULL      = 3'd2,
        ST_INIT_FAIL = 3'd3,
        ST_BAD_SLOT  = 3'd4
    } status_t;

    // write side of the handle store
    typedef struct packed {
        logic    en;
        slot_t   addr;
        handle_t desc;
        handle_t obj;
    } store_wr_t;

endpackage

// ===== rtl/ffa_handle_store.sv =====
// descriptor and object handle memories, one write port and one registered read port
module ffa_handle_store (
    input  logic                      clk,
    input  ffa_pkg::store_wr_t        wr,
    input  logic                      rd_en,
    input  ffa_pkg::slot_t            rd_addr,
    output ffa_pkg::handle_t          rd_desc,
    output ffa_pkg::handle_t          rd_obj
);

    ffa_pkg::handle_t desc_mem [ffa_pkg::SLOTS];
    ffa_pkg::handle_t obj_mem  [ffa_pkg::SLOTS];
    ffa_pkg::handle_t rd_desc_reg;
    ffa_pkg::handle_t rd_obj_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            desc_mem[wr.addr] <= wr.desc;
            obj_mem[wr.addr]  <= wr.obj;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_desc_reg <= desc_mem[rd_addr];
            rd_obj_reg  <= obj_mem[rd_addr];
        end
    end

    assign rd_desc = rd_desc_reg;
    assign rd_obj  = rd_obj_reg;

endmodule

// ===== rtl/fifo_free_list_id_allocator.sv =====
// top level of the slot allocator with a first-in first-out free list
// a request and its memory reads are registered at accept; S_EXEC then loads the result and done
// no new request is taken during S_EXEC, set by the read then write-back of the memories
// busy is high for the one cycle between the memory read and the write-back
// reset: all slots free in order 0 upward, no slot in use, no result pending
// results are shown for one cycle under done and cannot be held off by the receiver
module fifo_free_list_id_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [3:0]  entry_id,
    input  logic [31:0] desc_handle,
    input  logic [31:0] obj_handle,
    input  logic        init_ok,
    output logic        done,
    output logic [2:0]  status,
    output logic [2:0]  slot_out,
    output logic [31:0] desc_out,
    output logic [31:0] obj_out
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } fsm_t;

    fsm_t                 state_reg, state_next;
    logic                 accept;

    // request held for the execute cycle
    ffa_pkg::action_t     act_reg;
    logic [3:0]           id_reg;
    ffa_pkg::handle_t     desc_in_reg;
    ffa_pkg::handle_t     obj_in_reg;
    logic                 init_ok_reg;

    // free list control
    ffa_pkg::slot_t       head_reg, head_next;
    ffa_pkg::count_t      count_reg, count_next;
    logic [ffa_pkg::SLOTS-1:0] used_reg, used_next;
    logic [ffa_pkg::SLOTS-1:0] qvalid_reg, qvalid_next;

    // free queue memory
    ffa_pkg::slot_t       queue_mem [ffa_pkg::SLOTS];
    ffa_pkg::slot_t       queue_rd_reg;
    logic                 queue_we;
    ffa_pkg::slot_t       queue_waddr;
    ffa_pkg::slot_t       queue_wdata;

    // handle store
    ffa_pkg::store_wr_t   store_wr;
    ffa_pkg::handle_t     store_desc;
    ffa_pkg::handle_t     store_obj;

    // result
    logic                 done_reg;
    ffa_pkg::status_t     status_reg, status_next;
    logic [2:0]           slot_reg, slot_next;
    logic [31:0]          desc_out_reg, desc_out_next;
    logic [31:0]          obj_out_reg, obj_out_next;

    // execute-cycle helpers
    ffa_pkg::slot_t       id_slot;
    logic                 id_bad;
    ffa_pkg::slot_t       head_slot;

    assign busy   = (state_reg == S_EXEC);
    assign accept = start && !busy;

    // sequencer
    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            head_reg   <= '0;
            count_reg  <= ffa_pkg::COUNT_BITS'(ffa_pkg::SLOTS);
            used_reg   <= '0;
            qvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            used_reg   <= used_next;
            qvalid_reg <= qvalid_next;
            done_reg   <= busy;
        end
    end

    // capture the request
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg     <= ffa_pkg::action_t'(action);
            id_reg      <= entry_id;
            desc_in_reg <= ffa_pkg::handle_t'(desc_handle);
            obj_in_reg  <= ffa_pkg::handle_t'(obj_handle);
            init_ok_reg <= init_ok;
        end
    end

    // free queue: head read at accept, tail write at the end of execute;
    // the write lands before the next request can be taken
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_rd_reg <= queue_mem[head_reg];
        end
        if (queue_we)
        begin
            queue_mem[queue_waddr] <= queue_wdata;
        end
    end

    ffa_handle_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_en   (accept),
        .rd_addr (ffa_pkg::slot_t'(entry_id)),
        .rd_desc (store_desc),
        .rd_obj  (store_obj)
    );

    // an entry never written since reinitialise holds its own slot number
    assign head_slot = qvalid_reg[head_reg] ? queue_rd_reg : head_reg;
    assign id_slot   = ffa_pkg::slot_t'(id_reg);
    assign id_bad    = (32'(id_reg) >= ffa_pkg::SLOTS) || !used_reg[id_slot];

    // execute: check, update the free list, write back or return the stored handles
    always_comb
    begin
        head_next     = head_reg;
        count_next    = count_reg;
        used_next     = used_reg;
        qvalid_next   = qvalid_reg;
        queue_we      = 1'b0;
        queue_waddr   = ffa_pkg::slot_t'(head_reg + ffa_pkg::slot_t'(count_reg));
        queue_wdata   = id_slot;
        store_wr.en   = 1'b0;
        store_wr.addr = head_slot;
        store_wr.desc = desc_in_reg;
        store_wr.obj  = obj_in_reg;
        status_next   = ffa_pkg::ST_OK;
        slot_next     = 3'(id_reg);
        desc_out_next = '0;
        obj_out_next  = '0;
        if (busy)
        begin
            case (act_reg)
                ffa_pkg::ACT_REINIT:
                begin
                    head_next   = '0;
                    count_next  = ffa_pkg::COUNT_BITS'(ffa_pkg::SLOTS);
                    used_next   = '0;
                    qvalid_next = '0;
                    slot_next   = '0;
                end
                ffa_pkg::ACT_REGISTER:
                begin
                    if (desc_in_reg == '0)
                    begin
                        status_next = ffa_pkg::ST_NULL_DESC;
                        slot_next   = '0;
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = ffa_pkg::ST_FULL;
                        slot_next   = '0;
                    end
                    else if (!init_ok_reg)
                    begin
                        status_next = ffa_pkg::ST_INIT_FAIL;
                        slot_next   = 3'(head_slot);
                    end
                    else
                    begin
                        head_next            = head_reg + 1'b1;
                        count_next           = count_reg - 1'b1;
                        used_next[head_slot] = 1'b1;
                        store_wr.en          = 1'b1;
                        slot_next            = 3'(head_slot);
                    end
                end
                ffa_pkg::ACT_UNREGISTER:
                begin
                    if (id_bad || (32'(count_reg) >= ffa_pkg::SLOTS))
                    begin
                        status_next = ffa_pkg::ST_BAD_SLOT;
                    end
                    else
                    begin
                        queue_we                 = 1'b1;
                        qvalid_next[queue_waddr] = 1'b1;
                        count_next               = count_reg + 1'b1;
                        used_next[id_slot]       = 1'b0;
                    end
                end
                default:
                begin
                    if (id_bad)
                    begin
                        status_next = ffa_pkg::ST_BAD_SLOT;
                    end
                    else
                    begin
                        desc_out_next = 32'(store_desc);
                        obj_out_next  = 32'(store_obj);
                    end
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (busy)
        begin
            status_reg   <= status_next;
            slot_reg     <= slot_next;
            desc_out_reg <= desc_out_next;
            obj_out_reg  <= obj_out_next;
        end
    end

    assign done     = done_reg;
    assign status   = status_reg;
    assign slot_out = slot_reg;
    assign desc_out = desc_out_reg;
    assign obj_out  = obj_out_reg;

    // every result follows an execute cycle
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("done without an execute cycle");

    // free count never exceeds the table
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= ffa_pkg::SLOTS)
        else $error("free count beyond slot count");

    // the used slots and the free count always add up to the slot count
    a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (32'($countones(used_reg)) + 32'(count_reg)) == ffa_pkg::SLOTS)
        else $error("free count and used slots disagree");

    // no new request while one is executing
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC) && !accept)
        else $error("request overlapped execute");

endmodule
